// ===== design/tsof_pkg.sv =====
// shared types, constants and step codes for the trajectory slope outlier fix
`timescale 1ns / 1ps

package tsof_pkg;

	localparam int FIELD_W       = 32;
	localparam int POS_WIDTH_DEF = 32;
	localparam int MUL_STEPS     = 5;
	localparam int STEP_W        = $clog2(MUL_STEPS);

	// multiplier schedule: two cross products per slope pair, compare follows each pair
	localparam logic [STEP_W-1:0] STEP_P01   = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_Q01   = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_P12   = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_Q12   = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_CMP12 = STEP_W'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VEL,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} seq_state_t;

	// ordered so that the codes compare like the slopes they stand for
	typedef enum logic [1:0] {
		CLS_NAN,
		CLS_NEG_INF,
		CLS_FINITE,
		CLS_POS_INF
	} slope_cls_t;

	typedef enum logic [1:0] {
		ORD_LT,
		ORD_EQ,
		ORD_GT,
		ORD_UN
	} slope_ord_t;

	typedef struct packed {
		logic              in_ready;
		logic              vel_en;
		logic              mul_busy;
		logic [STEP_W-1:0] step;
		logic              fix_en;
		logic              emit_en;
	} seq_ctrl_t;

	typedef struct packed {
		logic accept;
		logic full;
		logic eot_in;
		logic eot_q;
		logic out_free;
		logic emit_last;
	} seq_stat_t;

endpackage

// ===== design/tsof_if.sv =====
// valid/ready stream interfaces for input states and emitted states
`timescale 1ns / 1ps

interface tsof_in_if;
	import tsof_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] pos_x;
	logic signed [FIELD_W-1:0] pos_y;
	logic signed [FIELD_W-1:0] disp_x;
	logic signed [FIELD_W-1:0] disp_y;
	logic                      end_of_table;

	modport source (output valid, pos_x, pos_y, disp_x, disp_y, end_of_table, input ready);
	modport sink   (input valid, pos_x, pos_y, disp_x, disp_y, end_of_table, output ready);
endinterface

interface tsof_out_if;
	import tsof_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] out_x;
	logic signed [FIELD_W-1:0] out_y;
	logic signed [FIELD_W-1:0] out_disp_x;
	logic signed [FIELD_W-1:0] out_disp_y;
	logic                      was_corrected;
	logic                      final_item;

	modport source (output valid, out_x, out_y, out_disp_x, out_disp_y, was_corrected,
		final_item, input ready);
	modport sink   (input valid, out_x, out_y, out_disp_x, out_disp_y, was_corrected,
		final_item, output ready);
endinterface

// ===== design/trajectory_slope_outlier_fix_core.sv =====
// top level: three-state window with slope monotonicity check and midpoint repair
// an item that fills no full window is taken and the block stays ready unless it ends the table
// an item that completes a window runs through accept, velocity, five multiplier steps and fix
// the multiplier steps use the single shared multiplier, one cross product per cycle
// at end of table each held state is flushed in turn; a stalled result holds the sequence
// reset empties the window and the output register; no clearing pass is needed
`timescale 1ns / 1ps

module trajectory_slope_outlier_fix_core #(
	parameter int POS_WIDTH = tsof_pkg::POS_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tsof_in_if.sink    states,
	tsof_out_if.source results
);
	import tsof_pkg::*;

	localparam int VW = POS_WIDTH + 1;

	seq_ctrl_t ctrl;
	seq_stat_t stat;

	logic signed [POS_WIDTH-1:0] in_x;
	logic signed [POS_WIDTH-1:0] in_y;
	logic signed [POS_WIDTH-1:0] in_dx;
	logic signed [POS_WIDTH-1:0] in_dy;

	logic signed [POS_WIDTH-1:0] win_x_q  [2];
	logic signed [POS_WIDTH-1:0] win_y_q  [2];
	logic signed [POS_WIDTH-1:0] win_dx_q [2];
	logic signed [POS_WIDTH-1:0] win_dy_q [2];
	logic                        win_fixed_q [2];
	logic [1:0]                  held_q;

	logic signed [POS_WIDTH-1:0] cur_x_q;
	logic signed [POS_WIDTH-1:0] cur_y_q;
	logic signed [POS_WIDTH-1:0] cur_dx_q;
	logic signed [POS_WIDTH-1:0] cur_dy_q;
	logic                        eot_q;

	logic signed [VW-1:0] vel_x_q [3];
	logic signed [VW-1:0] vel_y_q [3];
	slope_cls_t           cls [3];

	logic signed [VW-1:0] op_a;
	logic signed [VW-1:0] op_b;
	logic                 pair12;
	slope_cls_t           cls_a;
	slope_cls_t           cls_b;
	logic                 flip;
	logic                 mul_en;
	logic                 hold_first;
	slope_ord_t           ord;
	slope_ord_t           ord1_q;
	slope_ord_t           ord2_q;
	logic                 up;
	logic                 down;
	logic                 outlier;

	logic signed [VW-1:0]        diff_x;
	logic signed [VW-1:0]        diff_y;
	logic signed [POS_WIDTH-1:0] half_x;
	logic signed [POS_WIDTH-1:0] half_y;
	logic signed [POS_WIDTH-1:0] fix_x;
	logic signed [POS_WIDTH-1:0] fix_y;

	logic                        emit_idx_q;
	logic                        out_valid_q;
	logic signed [POS_WIDTH-1:0] out_x_q;
	logic signed [POS_WIDTH-1:0] out_y_q;
	logic signed [POS_WIDTH-1:0] out_dx_q;
	logic signed [POS_WIDTH-1:0] out_dy_q;
	logic                        out_fixed_q;
	logic                        out_final_q;

	// field width to internal width and back
	generate
		if (POS_WIDTH <= FIELD_W) begin : g_in_narrow
			assign in_x  = states.pos_x[POS_WIDTH-1:0];
			assign in_y  = states.pos_y[POS_WIDTH-1:0];
			assign in_dx = states.disp_x[POS_WIDTH-1:0];
			assign in_dy = states.disp_y[POS_WIDTH-1:0];
		end else begin : g_in_wide
			assign in_x  = {{(POS_WIDTH - FIELD_W){1'b0}}, states.pos_x};
			assign in_y  = {{(POS_WIDTH - FIELD_W){1'b0}}, states.pos_y};
			assign in_dx = {{(POS_WIDTH - FIELD_W){1'b0}}, states.disp_x};
			assign in_dy = {{(POS_WIDTH - FIELD_W){1'b0}}, states.disp_y};
		end

		if (POS_WIDTH >= FIELD_W) begin : g_out_narrow
			assign results.out_x      = out_x_q[FIELD_W-1:0];
			assign results.out_y      = out_y_q[FIELD_W-1:0];
			assign results.out_disp_x = out_dx_q[FIELD_W-1:0];
			assign results.out_disp_y = out_dy_q[FIELD_W-1:0];
		end else begin : g_out_wide
			assign results.out_x      = {{(FIELD_W - POS_WIDTH){out_x_q[POS_WIDTH-1]}}, out_x_q};
			assign results.out_y      = {{(FIELD_W - POS_WIDTH){out_y_q[POS_WIDTH-1]}}, out_y_q};
			assign results.out_disp_x = {{(FIELD_W - POS_WIDTH){out_dx_q[POS_WIDTH-1]}}, out_dx_q};
			assign results.out_disp_y = {{(FIELD_W - POS_WIDTH){out_dy_q[POS_WIDTH-1]}}, out_dy_q};
		end
	endgenerate

	assign states.ready          = ctrl.in_ready;
	assign results.valid         = out_valid_q;
	assign results.was_corrected = out_fixed_q;
	assign results.final_item    = out_final_q;

	assign stat.accept    = states.valid && ctrl.in_ready;
	assign stat.full      = held_q == 2'd2;
	assign stat.eot_in    = states.end_of_table;
	assign stat.eot_q     = eot_q;
	assign stat.out_free  = !out_valid_q || results.ready;
	assign stat.emit_last = held_q == ({1'b0, emit_idx_q} + 2'd1);

	tsof_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// window and held count
	always_ff @(posedge clk) begin
		if (stat.accept && !stat.full) begin
			win_x_q[held_q[0]]     <= in_x;
			win_y_q[held_q[0]]     <= in_y;
			win_dx_q[held_q[0]]    <= in_dx;
			win_dy_q[held_q[0]]    <= in_dy;
			win_fixed_q[held_q[0]] <= 1'b0;
		end else if (ctrl.fix_en) begin
			if (outlier) begin
				win_x_q[0]     <= fix_x;
				win_y_q[0]     <= fix_y;
				win_dx_q[0]    <= half_x;
				win_dy_q[0]    <= half_y;
				win_fixed_q[0] <= 1'b1;
			end else begin
				win_x_q[0]     <= win_x_q[1];
				win_y_q[0]     <= win_y_q[1];
				win_dx_q[0]    <= win_dx_q[1];
				win_dy_q[0]    <= win_dy_q[1];
				win_fixed_q[0] <= win_fixed_q[1];
			end
			win_x_q[1]     <= cur_x_q;
			win_y_q[1]     <= cur_y_q;
			win_dx_q[1]    <= cur_dx_q;
			win_dy_q[1]    <= cur_dy_q;
			win_fixed_q[1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 2'd0;
			emit_idx_q <= 1'b0;
			eot_q      <= 1'b0;
		end else begin
			if (stat.accept) begin
				eot_q <= states.end_of_table;
			end
			if (stat.accept && !stat.full) begin
				held_q <= held_q + 2'd1;
			end else if (ctrl.emit_en && stat.emit_last) begin
				held_q <= 2'd0;
			end
			if (ctrl.emit_en) begin
				emit_idx_q <= stat.emit_last ? 1'b0 : 1'b1;
			end
		end
	end

	// latest accepted state, which completes the window when the window is full
	always_ff @(posedge clk) begin
		if (stat.accept) begin
			cur_x_q  <= in_x;
			cur_y_q  <= in_y;
			cur_dx_q <= in_dx;
			cur_dy_q <= in_dy;
		end
	end

	// velocities of the three window states
	always_ff @(posedge clk) begin
		if (ctrl.vel_en) begin
			vel_x_q[0] <= VW'(win_x_q[0]) - VW'(win_dx_q[0]);
			vel_y_q[0] <= VW'(win_y_q[0]) - VW'(win_dy_q[0]);
			vel_x_q[1] <= VW'(win_x_q[1]) - VW'(win_dx_q[1]);
			vel_y_q[1] <= VW'(win_y_q[1]) - VW'(win_dy_q[1]);
			vel_x_q[2] <= VW'(cur_x_q) - VW'(cur_dx_q);
			vel_y_q[2] <= VW'(cur_y_q) - VW'(cur_dy_q);
		end
	end

	generate
		for (genvar i = 0; i < 3; i++) begin : g_cls
			always_comb begin
				if (vel_x_q[i] != '0) begin
					cls[i] = CLS_FINITE;
				end else if (vel_y_q[i] == '0) begin
					cls[i] = CLS_NAN;
				end else if (!vel_y_q[i][VW-1]) begin
					cls[i] = CLS_POS_INF;
				end else begin
					cls[i] = CLS_NEG_INF;
				end
			end
		end
	endgenerate

	// operand select: first pair is states 0,1 and second pair is states 1,2
	always_comb begin
		unique case (ctrl.step)
			STEP_P01: begin
				op_a = vel_y_q[0];
				op_b = vel_x_q[1];
			end
			STEP_Q01: begin
				op_a = vel_y_q[1];
				op_b = vel_x_q[0];
			end
			STEP_P12: begin
				op_a = vel_y_q[1];
				op_b = vel_x_q[2];
			end
			default: begin
				op_a = vel_y_q[2];
				op_b = vel_x_q[1];
			end
		endcase
	end

	assign pair12     = ctrl.step == STEP_CMP12;
	assign cls_a      = pair12 ? cls[1] : cls[0];
	assign cls_b      = pair12 ? cls[2] : cls[1];
	assign flip       = pair12 ? (vel_x_q[1][VW-1] ^ vel_x_q[2][VW-1])
	                           : (vel_x_q[0][VW-1] ^ vel_x_q[1][VW-1]);
	assign mul_en     = ctrl.mul_busy && !pair12;
	assign hold_first = ctrl.mul_busy && (ctrl.step == STEP_Q01 || ctrl.step == STEP_Q12);

	tsof_xmul #(
		.VW (VW)
	) u_xmul (
		.clk        (clk),
		.op_a       (op_a),
		.op_b       (op_b),
		.mul_en     (mul_en),
		.hold_first (hold_first),
		.cls_a      (cls_a),
		.cls_b      (cls_b),
		.flip       (flip),
		.ord        (ord)
	);

	always_ff @(posedge clk) begin
		if (ctrl.mul_busy && ctrl.step == STEP_P12) begin
			ord1_q <= ord;
		end
		if (ctrl.mul_busy && pair12) begin
			ord2_q <= ord;
		end
	end

	// an unordered slope fails both directions
	assign up      = (ord1_q == ORD_LT || ord1_q == ORD_EQ) && (ord2_q == ORD_LT || ord2_q == ORD_EQ);
	assign down    = (ord1_q == ORD_GT || ord1_q == ORD_EQ) && (ord2_q == ORD_GT || ord2_q == ORD_EQ);
	assign outlier = !up && !down;

	// midpoint repair, floor halving
	assign diff_x = VW'(cur_x_q) - VW'(win_x_q[0]);
	assign diff_y = VW'(cur_y_q) - VW'(win_y_q[0]);
	assign half_x = diff_x[VW-1:1];
	assign half_y = diff_y[VW-1:1];
	assign fix_x  = win_x_q[0] + half_x;
	assign fix_y  = win_y_q[0] + half_y;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fix_en || ctrl.emit_en) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fix_en) begin
			out_x_q     <= win_x_q[0];
			out_y_q     <= win_y_q[0];
			out_dx_q    <= win_dx_q[0];
			out_dy_q    <= win_dy_q[0];
			out_fixed_q <= win_fixed_q[0];
			out_final_q <= 1'b0;
		end else if (ctrl.emit_en) begin
			out_x_q     <= win_x_q[emit_idx_q];
			out_y_q     <= win_y_q[emit_idx_q];
			out_dx_q    <= win_dx_q[emit_idx_q];
			out_dy_q    <= win_dy_q[emit_idx_q];
			out_fixed_q <= win_fixed_q[emit_idx_q];
			out_final_q <= stat.emit_last;
		end
	end

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_en && stat.emit_last) |=> (held_q == 2'd0))
		else $error("window not empty after the final flushed item");

	a_fix_emits_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fix_en |=> (results.valid && !results.final_item))
		else $error("window shift did not present the oldest state");

	a_vel_full_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vel_en |-> (held_q == 2'd2))
		else $error("slope check started without a full window");

	a_busy_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.accept && stat.full) |=> !states.ready)
		else $error("ready while a window item is in work");

endmodule

// ===== design/tsof_xmul.sv =====
// shared signed multiplier with held first product and slope order compare
`timescale 1ns / 1ps

module tsof_xmul #(
	parameter int VW = tsof_pkg::POS_WIDTH_DEF + 1
) (
	input  logic                    clk,
	input  logic signed [VW-1:0]    op_a,
	input  logic signed [VW-1:0]    op_b,
	input  logic                    mul_en,
	input  logic                    hold_first,
	input  tsof_pkg::slope_cls_t    cls_a,
	input  tsof_pkg::slope_cls_t    cls_b,
	input  logic                    flip,
	output tsof_pkg::slope_ord_t    ord
);
	import tsof_pkg::*;

	localparam int PW = 2 * VW;

	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] first_q;
	logic                 lt_raw;
	logic                 eq_raw;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PW'(op_a) * PW'(op_b);
		end
		if (hold_first) begin
			first_q <= prod_q;
		end
	end

	assign lt_raw = first_q < prod_q;
	assign eq_raw = first_q == prod_q;

	always_comb begin
		if (cls_a == CLS_NAN || cls_b == CLS_NAN) begin
			ord = ORD_UN;
		end else if (cls_a != CLS_FINITE || cls_b != CLS_FINITE) begin
			if (cls_a < cls_b) begin
				ord = ORD_LT;
			end else if (cls_a > cls_b) begin
				ord = ORD_GT;
			end else begin
				ord = ORD_EQ;
			end
		end else if (eq_raw) begin
			ord = ORD_EQ;
		end else if (lt_raw ^ flip) begin
			// opposite vx signs reverse the cross-product order
			ord = ORD_LT;
		end else begin
			ord = ORD_GT;
		end
	end

endmodule

// ===== design/tsof_seq.sv =====
// sequencer that steps one state item through velocity, products, fix and flush
`timescale 1ns / 1ps

module tsof_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tsof_pkg::seq_stat_t stat,
	output tsof_pkg::seq_ctrl_t ctrl
);
	import tsof_pkg::*;

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.accept) begin
					if (stat.full) begin
						state_d = ST_VEL;
					end else if (stat.eot_in) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_VEL: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == STEP_CMP12) begin
					state_d = ST_FIX;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_FIX: begin
				if (stat.out_free) begin
					state_d = stat.eot_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.step     = step_q;
		ctrl.in_ready = state_q == ST_IDLE;
		ctrl.vel_en   = state_q == ST_VEL;
		ctrl.mul_busy = state_q == ST_MUL;
		ctrl.fix_en   = (state_q == ST_FIX) && stat.out_free;
		ctrl.emit_en  = (state_q == ST_EMIT) && stat.out_free;
	end

endmodule

// ===== sim/trajectory_slope_outlier_fix_core_test.sv =====
// self-checking testbench for the trajectory slope outlier fix core
`timescale 1ns / 1ps

module trajectory_slope_outlier_fix_core_test;
	import tsof_pkg::*;

	localparam int LIMIT_CYCLES    = 400000;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int DRAIN_CYCLES    = 30;
	localparam int WIDE_W          = 2 * FIELD_W + 4;

	localparam logic [FIELD_W-1:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [FIELD_W-1:0] POS_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] dx;
		logic signed [FIELD_W-1:0] dy;
		logic                      corrected;
	} track_state_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] dx;
		logic signed [FIELD_W-1:0] dy;
		logic                      corrected;
		logic                      last;
	} emitted_state_t;

	logic clk = 1'b0;
	logic arst_n;

	int cycle_count = 0;
	int err_count = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_pct = 0;
	bit hold_off_req = 1'b0;

	// window as the block should hold it, and the states it still owes
	track_state_t   held_states[2];
	int             held_n = 0;
	emitted_state_t pending_states[$];

	tsof_in_if  states();
	tsof_out_if results();

	trajectory_slope_outlier_fix_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.states (states),
		.results(results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("trajectory_slope_outlier_fix_core_test: done, errors");
			$finish;
		end
	end

	function automatic slope_cls_t slope_class_of(input logic signed [WIDE_W-1:0] vx,
		input logic signed [WIDE_W-1:0] vy);
		if (vx != 0)
			return CLS_FINITE;
		if (vy == 0)
			return CLS_NAN;
		return (vy > 0) ? CLS_POS_INF : CLS_NEG_INF;
	endfunction

	function automatic slope_ord_t compare_slopes(input track_state_t a, input track_state_t b);
		logic signed [WIDE_W-1:0] ax, ay, bx, by, lhs, rhs;
		slope_cls_t ca, cb;
		ax = $signed(a.x) - $signed(a.dx);
		ay = $signed(a.y) - $signed(a.dy);
		bx = $signed(b.x) - $signed(b.dx);
		by = $signed(b.y) - $signed(b.dy);
		ca = slope_class_of(ax, ay);
		cb = slope_class_of(bx, by);
		if (ca == CLS_NAN || cb == CLS_NAN)
			return ORD_UN;
		if (ca != CLS_FINITE || cb != CLS_FINITE) begin
			if (ca < cb)
				return ORD_LT;
			return (ca > cb) ? ORD_GT : ORD_EQ;
		end
		// make both run components positive so cross products keep the order
		if (ax < 0) begin
			ax = -ax;
			ay = -ay;
		end
		if (bx < 0) begin
			bx = -bx;
			by = -by;
		end
		lhs = ay * bx;
		rhs = by * ax;
		if (lhs < rhs)
			return ORD_LT;
		return (lhs > rhs) ? ORD_GT : ORD_EQ;
	endfunction

	function automatic emitted_state_t to_emitted(input track_state_t t, input logic last);
		emitted_state_t e;
		e.x = t.x;
		e.y = t.y;
		e.dx = t.dx;
		e.dy = t.dy;
		e.corrected = t.corrected;
		e.last = last;
		return e;
	endfunction

	task automatic emit_expected_states(input track_state_t incoming, input logic eot);
		track_state_t first, middle;
		slope_ord_t c1, c2;
		logic rising, falling;
		logic signed [FIELD_W+1:0] diff_x, diff_y, half_x, half_y;
		if (held_n == 2) begin
			first = held_states[0];
			middle = held_states[1];
			c1 = compare_slopes(first, middle);
			c2 = compare_slopes(middle, incoming);
			rising = (c1 == ORD_LT || c1 == ORD_EQ) && (c2 == ORD_LT || c2 == ORD_EQ);
			falling = (c1 == ORD_GT || c1 == ORD_EQ) && (c2 == ORD_GT || c2 == ORD_EQ);
			if (!rising && !falling) begin
				// floor halving of the span between the neighbours
				diff_x = $signed(incoming.x) - $signed(first.x);
				diff_y = $signed(incoming.y) - $signed(first.y);
				half_x = diff_x >>> 1;
				half_y = diff_y >>> 1;
				middle.x = FIELD_W'($signed(first.x) + half_x);
				middle.y = FIELD_W'($signed(first.y) + half_y);
				middle.dx = FIELD_W'(half_x);
				middle.dy = FIELD_W'(half_y);
				middle.corrected = 1'b1;
			end
			pending_states.push_back(to_emitted(first, 1'b0));
			held_states[0] = middle;
			held_states[1] = incoming;
		end else begin
			held_states[held_n] = incoming;
			held_n++;
		end
		if (eot) begin
			for (int s = 0; s < held_n; s++)
				pending_states.push_back(to_emitted(held_states[s], s + 1 == held_n));
			held_n = 0;
		end
	endtask

	task automatic send_state(input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] py,
		input logic [FIELD_W-1:0] dx, input logic [FIELD_W-1:0] dy, input logic eot);
		int gap;
		track_state_t incoming;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				states.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		states.valid <= 1'b1;
		states.pos_x <= px;
		states.pos_y <= py;
		states.disp_x <= dx;
		states.disp_y <= dy;
		states.end_of_table <= eot;
		do
			@(posedge clk);
		while (states.ready !== 1'b1);
		incoming.x = px;
		incoming.y = py;
		incoming.dx = dx;
		incoming.dy = dy;
		incoming.corrected = 1'b0;
		emit_expected_states(incoming, eot);
		burst_left--;
	endtask

	function automatic logic [FIELD_W-1:0] rand_field();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return POS_MAX;
					1: return POS_MIN;
					2: return '0;
					3: return '1;
					default: return 32'd1;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return 32'($urandom_range(0, 2000)) - 32'd1000;
		endcase
	endfunction

	// smooth tracks with jitter, vertical steps and outliers, or plain noise
	task automatic send_table(input int len, input bit noisy);
		logic [FIELD_W-1:0] px, py, vx, vy, base_vx, base_vy;
		px = rand_field();
		py = rand_field();
		base_vx = 32'($urandom_range(0, 100)) - 32'd50;
		base_vy = 32'($urandom_range(0, 100)) - 32'd50;
		for (int k = 0; k < len; k++) begin
			if (noisy) begin
				send_state(rand_field(), rand_field(), rand_field(), rand_field(), k == len - 1);
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						vx = rand_field();
						vy = rand_field();
					end
					1: begin
						vx = '0;
						vy = 32'($urandom_range(0, 4)) - 32'd2;
					end
					default: begin
						base_vy = base_vy + 32'($urandom_range(0, 2)) - 32'd1;
						vx = base_vx + 32'($urandom_range(0, 4)) - 32'd2;
						vy = base_vy + 32'($urandom_range(0, 4)) - 32'd2;
					end
				endcase
				px = px + vx;
				py = py + vy;
				send_state(px, py, px - vx, py - vy, k == len - 1);
			end
		end
	endtask

	// compare every delivered state with the oldest one owed
	always @(posedge clk) begin : check_results
		emitted_state_t want;
		if (results.valid === 1'b1 && results.ready === 1'b1) begin
			if (pending_states.size() == 0) begin
				$error("unexpected item: out_x %0d out_y %0d", results.out_x, results.out_y);
				err_count++;
			end else begin
				want = pending_states.pop_front();
				if (results.out_x !== want.x) begin
					$error("out_x: expected %0d, actual %0d", want.x, results.out_x);
					err_count++;
				end
				if (results.out_y !== want.y) begin
					$error("out_y: expected %0d, actual %0d", want.y, results.out_y);
					err_count++;
				end
				if (results.out_disp_x !== want.dx) begin
					$error("out_disp_x: expected %0d, actual %0d", want.dx, results.out_disp_x);
					err_count++;
				end
				if (results.out_disp_y !== want.dy) begin
					$error("out_disp_y: expected %0d, actual %0d", want.dy, results.out_disp_y);
					err_count++;
				end
				if (results.was_corrected !== want.corrected) begin
					$error("was_corrected: expected %0d, actual %0d", want.corrected,
						results.was_corrected);
					err_count++;
				end
				if (results.final_item !== want.last) begin
					$error("final_item: expected %0d, actual %0d", want.last, results.final_item);
					err_count++;
				end
			end
		end
	end

	initial begin : drain_results
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				results.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			results.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic test_short_tables();
		gap_max = 2;
		stall_pct = 20;
		send_state(32'sd5, -32'sd7, 32'sd1, 32'sd2, 1'b1);
		send_state(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b0);
		send_state(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 1'b1);
	endtask

	task automatic test_slope_cases();
		// slope 1, plus infinity, one half: peak in the middle gets repaired
		send_state(32'sd10, 32'sd10, 32'sd9, 32'sd9, 1'b0);
		send_state(32'sd20, 32'sd25, 32'sd20, 32'sd20, 1'b0);
		send_state(32'sd30, 32'sd31, 32'sd28, 32'sd30, 1'b0);
		// zero velocity is unordered, then minus infinity
		send_state(32'sd40, 32'sd40, 32'sd40, 32'sd40, 1'b0);
		send_state(32'sd50, 32'sd47, 32'sd50, 32'sd50, 1'b0);
		send_state(32'sd60, 32'sd56, 32'sd56, 32'sd60, 1'b0);
		// equal slopes from opposite run directions
		send_state(32'sd70, 32'sd70, 32'sd71, 32'sd69, 1'b0);
		// widest velocities in both directions
		send_state(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 1'b0);
		send_state(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 1'b0);
		send_state(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b0);
		send_state(-32'sd1, -32'sd1, 32'sd0, 32'sd0, 1'b1);
		// monotonic window passes untouched
		send_state(32'sd1, 32'sd0, 32'sd0, 32'sd0, 1'b0);
		send_state(32'sd2, 32'sd1, 32'sd1, 32'sd0, 1'b0);
		send_state(32'sd3, 32'sd2, 32'sd2, 32'sd0, 1'b1);
		// repair with an odd negative span rounds toward minus infinity
		send_state(32'sd0, 32'sd0, -32'sd1, -32'sd1, 1'b0);
		send_state(32'sd100, 32'sd100, 32'sd99, 32'sd95, 1'b0);
		send_state(-32'sd3, -32'sd3, -32'sd4, -32'sd5, 1'b1);
	endtask

	task automatic test_output_backpressure();
		gap_max = 0;
		stall_pct = 0;
		hold_off_req = 1'b1;
		send_table(16, 1'b0);
	endtask

	task automatic test_random_tables(input int n_items, input int gaps, input int stall);
		int sent;
		int len;
		sent = 0;
		gap_max = gaps;
		stall_pct = stall;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
			send_table(len, $urandom_range(0, 4) == 0);
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		states.valid = 1'b0;
		states.pos_x = '0;
		states.pos_y = '0;
		states.disp_x = '0;
		states.disp_y = '0;
		states.end_of_table = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_tables();
		test_slope_cases();
		test_output_backpressure();
		test_random_tables(40, 0, 0);
		test_random_tables(40, 8, 0);
		test_random_tables(40, 0, 60);
		test_random_tables(40, 6, 40);

		@(negedge clk);
		states.valid <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("trajectory_slope_outlier_fix_core_test: done, clean");
		else
			$display("trajectory_slope_outlier_fix_core_test: done, errors");
		$finish;
	end

endmodule
